// ===== sv/pgy_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pgy_pkg
// Shared types and constants for the prism gravity y-component accumulator.
// ----------------------------------------------------------------------------
package pgy_pkg;

	localparam int CoordW   = 32;
	localparam int SizeW    = 31;
	localparam int DensW    = 32;
	localparam int SumW     = 48;
	localparam int DiffW    = 35;
	localparam int RadW     = 72;
	localparam int RootW    = 36;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 32;
	localparam int ScaleW   = 32;
	localparam int ThreshW  = 31;

	// ln(2) in Q.24.
	localparam logic [23:0] LN2_Q24 = 24'd11629080;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_SCALE  = 2'd0,
		CFG_THRESH = 2'd1
	} pgy_cfg_idx_t;

	typedef struct packed {
		logic signed [CoordW-1:0] obs_x;
		logic signed [CoordW-1:0] obs_y;
		logic signed [CoordW-1:0] obs_z;
		logic signed [CoordW-1:0] centre_x;
		logic signed [CoordW-1:0] centre_y;
		logic signed [CoordW-1:0] centre_z;
		logic [SizeW-1:0]         size_x;
		logic [SizeW-1:0]         size_y;
		logic [SizeW-1:0]         size_z;
		logic signed [DensW-1:0]  density;
		logic                     last_prism;
	} pgy_in_t;

	typedef struct packed {
		logic signed [SumW-1:0] gy_value;
		logic                   domain_error;
	} pgy_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_RGO,
		ST_RWAIT,
		ST_ARG,
		ST_NORM,
		ST_LOG,
		ST_CEND,
		ST_LN2,
		ST_SCL,
		ST_DLO,
		ST_DHI,
		ST_ACC,
		ST_FIN
	} pgy_state_t;

endpackage
`default_nettype wire

// ===== sv/pgy_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pgy_isqrt
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pgy_isqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [pgy_pkg::RadW-1:0]  radicand,
	output logic                           done,
	output logic [pgy_pkg::RootW-1:0]      root
);
	import pgy_pkg::*;

	localparam int RemW = RootW + 2;
	localparam int CntW = $clog2(RootW);

	logic [RadW-1:0]  rad_q;
	logic [RemW-1:0]  rem_q;
	logic [RootW-1:0] root_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [RemW+1:0] rem_sh;
	logic [RemW+1:0] trial;
	logic            ge;
	logic [RemW+1:0] rem_sub;

	assign rem_sh  = {rem_q, rad_q[RadW-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign ge      = rem_sh >= trial;
	assign rem_sub = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CntW'(RootW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RadW-3:0], 2'b00};
			rem_q  <= ge ? rem_sub[RemW-1:0] : rem_sh[RemW-1:0];
			root_q <= {root_q[RootW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// ===== sv/prism_gravity_gy_accumulate.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prism_gravity_gy_accumulate
// Accumulates the y-component gravity of rectangular prisms at one
// observation point and emits the sum on the prism marked last.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_ready | in_data  (pgy_in_t)
//  out     | output    | out_valid/out_ready | out_data (pgy_out_t)
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// For each of the eight corners a prism runs the 36-step square root, then a
// normalize shift of N (0..35) places and 24 log squarings on the one shared
// 32x32 multiplier; a corner whose log argument is at or below zero skips the
// normalize and log steps.
// A skipped prism goes to ST_FIN. Reset clears the sum and the error flag.
// A finished sum waits in the output register; a following last prism
// holds in its final state until that register is taken.
module prism_gravity_gy_accumulate (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire pgy_pkg::pgy_in_t             in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output pgy_pkg::pgy_out_t                 out_data,
	input  wire logic                         cfg_we,
	input  wire logic [pgy_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [pgy_pkg::CfgDataW-1:0] cfg_data
);
	import pgy_pkg::*;

	pgy_state_t state_q, state_d;

	logic [ScaleW-1:0]  scale_q;
	logic [ThreshW-1:0] thresh_q;

	logic signed [DiffW-1:0] dxl_q, dxh_q, dyl_q, dyh_q, dzl_q, dzh_q;
	logic [DensW-1:0]        dmag_q;
	logic                    dens_neg_q;
	logic                    last_q;

	logic [1:0]              axis_q, part_q;
	logic [2:0]              corner_q;
	logic [69:0]             r2_q;
	logic [RootW-1:0]        n_q;
	logic [5:0]              e_q;
	logic [31:0]             m_q;
	logic [23:0]             frac_q;
	logic [4:0]              cnt_q;
	logic signed [31:0]      g_q;
	logic signed [33:0]      s_q;
	logic                    s_neg_q;
	logic [31:0]             lmag_q;
	logic [63:0]             p_q;
	logic [95:0]             q_q;

	logic signed [SumW-1:0]  sum_q;
	logic                    err_q;
	logic                    out_valid_q;
	pgy_out_t                out_q;

	// Input side helpers.
	logic [DensW-1:0]        dmag_in;
	logic                    skip_in;
	logic                    accept;

	assign dmag_in = in_data.density[DensW-1] ? (~in_data.density + 1'b1) : in_data.density;
	assign skip_in = dmag_in <= {1'b0, thresh_q};
	assign accept  = in_valid && in_ready;

	function automatic logic signed [DiffW-1:0] corner_diff(
		input logic signed [CoordW-1:0] c,
		input logic signed [CoordW-1:0] o,
		input logic [SizeW-1:0]         sz,
		input logic                     upper
	);
		logic signed [DiffW-1:0] c2;
		logic signed [DiffW-1:0] o2;
		logic signed [DiffW-1:0] szx;
		c2  = {{(DiffW-CoordW-1){c[CoordW-1]}}, c, 1'b0};
		o2  = {{(DiffW-CoordW-1){o[CoordW-1]}}, o, 1'b0};
		szx = {{(DiffW-SizeW){1'b0}}, sz};
		return upper ? (c2 + szx - o2) : (c2 - szx - o2);
	endfunction

	// Corner offsets for the current corner.
	logic signed [DiffW-1:0] dsel_x, dsel_ax;
	logic [DiffW-2:0]        mag_ax;
	always_comb begin
		dsel_x = corner_q[2] ? dxh_q : dxl_q;
		unique case (axis_q)
			2'd0:    dsel_ax = dsel_x;
			2'd1:    dsel_ax = corner_q[1] ? dyh_q : dyl_q;
			default: dsel_ax = corner_q[0] ? dzh_q : dzl_q;
		endcase
		mag_ax = dsel_ax[DiffW-1] ? (DiffW-1)'(-dsel_ax) : dsel_ax[DiffW-2:0];
	end

	// Shared square root unit.
	logic             root_start;
	logic             root_done;
	logic [RootW-1:0] root;

	pgy_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand ({2'b00, r2_q}),
		.done     (root_done),
		.root     (root)
	);

	// Shared multiplier.
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	assign mul_p = mul_a * mul_b;

	logic signed [DiffW+1:0] arg;
	assign arg = {{2{dsel_x[DiffW-1]}}, dsel_x} + {1'b0, root};

	logic [32:0] sq_t;
	assign sq_t = mul_p[63:31];

	logic [33:0] smag;
	assign smag = s_q[33] ? 34'(-s_q) : s_q;

	logic [63:0] ln_round;
	assign ln_round = mul_p + 64'd8388608;

	logic [47:0]        termmag;
	logic signed [49:0] sum_wide;
	logic signed [49:0] sum_max, sum_min;
	assign termmag  = q_q[95:48];
	assign sum_max  = 50'sd140737488355327;
	assign sum_min  = -50'sd140737488355328;
	assign sum_wide = (s_neg_q ^ dens_neg_q)
		? ({{2{sum_q[SumW-1]}}, sum_q} - {2'b00, termmag})
		: ({{2{sum_q[SumW-1]}}, sum_q} + {2'b00, termmag});

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = skip_in ? ST_FIN : ST_SQ;
			ST_SQ:    if (axis_q == 2'd2 && part_q == 2'd2) state_d = ST_RGO;
			ST_RGO:   state_d = ST_RWAIT;
			ST_RWAIT: if (root_done) state_d = ST_ARG;
			ST_ARG:   state_d = (arg <= 0) ? ST_CEND : ST_NORM;
			ST_NORM:  if (n_q[RootW-1]) state_d = ST_LOG;
			ST_LOG:   if (cnt_q == 5'd23) state_d = ST_CEND;
			ST_CEND:  state_d = (corner_q == 3'd7) ? ST_LN2 : ST_SQ;
			ST_LN2:   state_d = ST_SCL;
			ST_SCL:   state_d = ST_DLO;
			ST_DLO:   state_d = ST_DHI;
			ST_DHI:   state_d = ST_ACC;
			ST_ACC:   state_d = ST_FIN;
			ST_FIN:   if (!last_q || !out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs and multiplier operand selection.
	always_comb begin
		in_ready   = 1'b0;
		root_start = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SQ: begin
				unique case (part_q)
					2'd0: begin
						mul_a = {15'd0, mag_ax[33:17]};
						mul_b = {15'd0, mag_ax[33:17]};
					end
					2'd1: begin
						mul_a = {15'd0, mag_ax[33:17]};
						mul_b = {15'd0, mag_ax[16:0]};
					end
					default: begin
						mul_a = {15'd0, mag_ax[16:0]};
						mul_b = {15'd0, mag_ax[16:0]};
					end
				endcase
			end
			ST_RGO: root_start = 1'b1;
			ST_LOG: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			ST_LN2: begin
				mul_a = smag[31:0];
				mul_b = {8'd0, LN2_Q24};
			end
			ST_SCL: begin
				mul_a = lmag_q;
				mul_b = scale_q;
			end
			ST_DLO: begin
				mul_a = p_q[31:0];
				mul_b = dmag_q;
			end
			ST_DHI: begin
				mul_a = p_q[63:32];
				mul_b = dmag_q;
			end
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scale_q     <= '0;
			thresh_q    <= '0;
			sum_q       <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == CFG_SCALE)
					scale_q <= cfg_data[ScaleW-1:0];
				else if (cfg_index == CFG_THRESH)
					thresh_q <= cfg_data[ThreshW-1:0];
			end
			if (state_q == ST_ARG && arg <= 0)
				err_q <= 1'b1;
			if (state_q == ST_ACC) begin
				if (sum_wide > sum_max)
					sum_q <= sum_max[SumW-1:0];
				else if (sum_wide < sum_min)
					sum_q <= sum_min[SumW-1:0];
				else
					sum_q <= sum_wide[SumW-1:0];
			end
			if (state_q == ST_FIN && last_q && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				sum_q       <= '0;
				err_q       <= 1'b0;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					dxl_q      <= corner_diff(in_data.centre_x, in_data.obs_x, in_data.size_x, 1'b0);
					dxh_q      <= corner_diff(in_data.centre_x, in_data.obs_x, in_data.size_x, 1'b1);
					dyl_q      <= corner_diff(in_data.centre_y, in_data.obs_y, in_data.size_y, 1'b0);
					dyh_q      <= corner_diff(in_data.centre_y, in_data.obs_y, in_data.size_y, 1'b1);
					dzl_q      <= corner_diff(in_data.centre_z, in_data.obs_z, in_data.size_z, 1'b0);
					dzh_q      <= corner_diff(in_data.centre_z, in_data.obs_z, in_data.size_z, 1'b1);
					dmag_q     <= dmag_in;
					dens_neg_q <= in_data.density[DensW-1];
					last_q     <= in_data.last_prism;
					axis_q     <= '0;
					part_q     <= '0;
					corner_q   <= '0;
					r2_q       <= '0;
					s_q        <= '0;
				end
			end
			ST_SQ: begin
				unique case (part_q)
					2'd0:    r2_q <= r2_q + ({6'd0, mul_p} << 34);
					2'd1:    r2_q <= r2_q + ({6'd0, mul_p} << 18);
					default: r2_q <= r2_q + {6'd0, mul_p};
				endcase
				if (part_q == 2'd2) begin
					part_q <= '0;
					axis_q <= axis_q + 1'b1;
				end else begin
					part_q <= part_q + 1'b1;
				end
			end
			ST_ARG: begin
				// A log argument at or below zero contributes nothing.
				g_q <= '0;
				n_q <= arg[RootW-1:0];
				e_q <= 6'd35;
			end
			ST_NORM: begin
				if (n_q[RootW-1]) begin
					m_q    <= n_q[RootW-1:4];
					frac_q <= '0;
					cnt_q  <= '0;
				end else begin
					n_q <= {n_q[RootW-2:0], 1'b0};
					e_q <= e_q - 1'b1;
				end
			end
			ST_LOG: begin
				m_q    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
				frac_q <= {frac_q[22:0], sq_t[32]};
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == 5'd23)
					g_q <= {8'({2'b00, e_q}) - 8'd9, frac_q[22:0], sq_t[32]};
			end
			ST_CEND: begin
				// Corners with an odd number of lower bounds are subtracted.
				if (^corner_q)
					s_q <= s_q + 34'(g_q);
				else
					s_q <= s_q - 34'(g_q);
				corner_q <= corner_q + 1'b1;
				axis_q   <= '0;
				part_q   <= '0;
				r2_q     <= '0;
			end
			ST_LN2: begin
				lmag_q  <= ln_round[55:24];
				s_neg_q <= s_q[33];
			end
			ST_SCL: p_q <= mul_p;
			ST_DLO: q_q <= {32'd0, mul_p};
			ST_DHI: q_q <= q_q + {mul_p, 32'd0} + (96'd1 << 47);
			default: ;
		endcase
		if (state_q == ST_FIN && last_q && (!out_valid_q || out_ready)) begin
			out_q.gy_value     <= sum_q;
			out_q.domain_error <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
